FILE: hdl/sliding_window_median_assert.svh
// Assertion macros for the sliding window median block.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SWM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swm assertion failed");
// Next-cycle implication, checked out of reset.
`define SWM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swm assertion failed");
`else
`define SWM_ASSERT_IMP(lbl, ante, cons)
`define SWM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/swm_pkg.sv
// Package for the sliding window median block: window size, widths and types.
// No dependencies.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int WINDOW   = 15;
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);

    localparam logic [SAMPLE_W-1:0] SENTINEL = '0;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [CNT_W-1:0]    t_cnt;

endpackage

FILE: hdl/swm_sample_if.sv
// Input channel of the sliding window median block: one sample per beat.
// Depends on swm_pkg.
`timescale 1ns / 1ps

interface swm_sample_if import swm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: hdl/swm_median_if.sv
// Output channel of the sliding window median block: one median per beat.
// Depends on swm_pkg.
`timescale 1ns / 1ps

interface swm_median_if import swm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample median_value;

    modport source (output valid, output median_value, input ready);
    modport sink   (input valid, input median_value, output ready);
endinterface

FILE: hdl/sliding_window_median.sv
// Takes one sample at a time: a new sample is accepted only in idle, once the previous
// one has been merged into the sorted memory and its median passed to the output register.
// The pace is set by the single-port walk through the sorted memory (one entry a cycle),
// over every sample held before the beat; a result still held in the output register
// stalls the finish step until it is taken.
// Synchronous active-low reset clears the control state; no memory clearing pass.
`timescale 1ns / 1ps
`include "sliding_window_median_assert.svh"

module sliding_window_median import swm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    swm_sample_if.sink   i_smp,
    swm_median_if.source o_med
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_OLD  = 5'b00010,
        S_WALK = 5'b00100,
        S_END  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    // Ring memory holds samples in arrival order; sorted memory holds them ascending.
    t_sample ring_mem [WINDOW];
    t_sample sort_mem [WINDOW];
    t_sample ring_rdata;
    t_sample sort_rdata;

    t_state  r_state, n_state;
    t_sample r_new, n_new;
    t_sample r_old, n_old;
    t_idx    r_wp, n_wp;
    t_cnt    r_fill, n_fill;
    logic    r_full, n_full;
    t_cnt    r_m, n_m;
    t_cnt    r_n, n_n;
    t_cnt    r_rank, n_rank;
    t_cnt    r_rk, n_rk;
    t_cnt    r_wj, n_wj;
    t_sample r_carry, n_carry;
    logic    r_has_carry, n_has_carry;
    logic    r_ins, n_ins;
    logic    r_rem, n_rem;
    t_sample r_med, n_med;
    logic    r_ovalid, n_ovalid;
    t_sample r_odata, n_odata;

    logic    accept;
    logic    ring_we;
    logic    s_re;
    t_idx    s_raddr;
    logic    s_we;
    t_idx    s_waddr;
    t_sample s_wdata;

    assign accept       = i_smp.valid && i_smp.ready;
    assign i_smp.ready  = (r_state == S_IDLE);
    assign o_med.valid  = r_ovalid;
    assign o_med.median_value = r_odata;

    // Ring read happens on the accept beat, the write to the same entry in the cycle after.
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[r_wp] <= r_new;
        end
        if (accept) begin
            ring_rdata <= ring_mem[r_wp];
        end
    end

    // Writes always land at or below the entry just read, reads run ahead: no overlap.
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            sort_mem[s_waddr] <= s_wdata;
        end
        if (s_re) begin
            sort_rdata <= sort_mem[s_raddr];
        end
    end

    always_comb begin
        logic    emit;
        t_sample emit_v;
        t_cnt    nxt;

        n_state     = r_state;
        n_new       = r_new;
        n_old       = r_old;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_full      = r_full;
        n_m         = r_m;
        n_n         = r_n;
        n_rank      = r_rank;
        n_rk        = r_rk;
        n_wj        = r_wj;
        n_carry     = r_carry;
        n_has_carry = r_has_carry;
        n_ins       = r_ins;
        n_rem       = r_rem;
        n_med       = r_med;
        n_ovalid    = r_ovalid;
        n_odata     = r_odata;
        ring_we     = 1'b0;
        s_re        = 1'b0;
        s_raddr     = '0;
        emit        = 1'b0;
        emit_v      = '0;
        nxt         = r_rk + CNT_W'(1);

        if (r_ovalid && o_med.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_new   = (i_smp.sample == SENTINEL) ? SENTINEL + SAMPLE_W'(1)
                                                         : i_smp.sample;
                    n_state = S_OLD;
                end
            end
            S_OLD: begin
                n_old   = ring_rdata;
                ring_we = 1'b1;
                n_wp    = (r_wp == IDX_W'(WINDOW - 1)) ? '0 : r_wp + IDX_W'(1);
                n_full  = (r_fill == CNT_W'(WINDOW));
                n_m     = r_fill;
                n_n     = n_full ? r_fill : r_fill + CNT_W'(1);
                n_rank  = (n_n - CNT_W'(1)) >> 1;
                n_wj        = '0;
                n_has_carry = 1'b0;
                n_ins       = 1'b0;
                n_rem       = 1'b0;
                n_rk        = '0;
                if (r_fill != '0) begin
                    s_re    = 1'b1;
                    n_state = S_WALK;
                end else begin
                    n_state = S_END;
                end
            end
            S_WALK: begin
                // Merge step: drop the evicted sample once, slot the new one in order.
                if (r_full && !r_rem && sort_rdata == r_old) begin
                    n_rem = 1'b1;
                    if (r_has_carry) begin
                        emit        = 1'b1;
                        emit_v      = r_carry;
                        n_has_carry = 1'b0;
                    end
                end else if (r_has_carry) begin
                    emit    = 1'b1;
                    emit_v  = r_carry;
                    n_carry = sort_rdata;
                end else if (!r_ins && r_new < sort_rdata) begin
                    emit        = 1'b1;
                    emit_v      = r_new;
                    n_carry     = sort_rdata;
                    n_has_carry = 1'b1;
                    n_ins       = 1'b1;
                end else begin
                    emit   = 1'b1;
                    emit_v = sort_rdata;
                end
                if (nxt < r_m) begin
                    s_re    = 1'b1;
                    s_raddr = nxt[IDX_W-1:0];
                    n_rk    = nxt;
                end else begin
                    n_state = S_END;
                end
            end
            S_END: begin
                // Flush the held entry, or append the new sample at the top.
                if (r_has_carry) begin
                    emit        = 1'b1;
                    emit_v      = r_carry;
                    n_has_carry = 1'b0;
                end else if (!r_ins) begin
                    emit   = 1'b1;
                    emit_v = r_new;
                    n_ins  = 1'b1;
                end
                n_fill  = r_n;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || o_med.ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_med;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        s_we    = emit;
        s_waddr = r_wj[IDX_W-1:0];
        s_wdata = emit_v;
        if (emit) begin
            n_wj = r_wj + CNT_W'(1);
            if (r_wj == r_rank) begin
                n_med = emit_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_full      <= 1'b0;
            r_m         <= '0;
            r_n         <= '0;
            r_rank      <= '0;
            r_rk        <= '0;
            r_wj        <= '0;
            r_has_carry <= 1'b0;
            r_ins       <= 1'b0;
            r_rem       <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_full      <= n_full;
            r_m         <= n_m;
            r_n         <= n_n;
            r_rank      <= n_rank;
            r_rk        <= n_rk;
            r_wj        <= n_wj;
            r_has_carry <= n_has_carry;
            r_ins       <= n_ins;
            r_rem       <= n_rem;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new   <= n_new;
        r_old   <= n_old;
        r_carry <= n_carry;
        r_med   <= n_med;
        r_odata <= n_odata;
    end

    `SWM_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= CNT_W'(WINDOW))
    `SWM_ASSERT_IMP(a_sorted_len, r_state == S_FIN, r_wj == r_n && r_ins && !r_has_carry)
    `SWM_ASSERT_IMP(a_evict_seen, r_state == S_END && r_full, r_rem)
    `SWM_ASSERT_NXT(a_med_nonzero, r_state == S_FIN && n_state == S_IDLE, r_odata != SENTINEL)

endmodule

FILE: test/sliding_window_median_tb.sv
`timescale 1ns / 1ps
// Testbench for sliding_window_median: sends sample beats and predicts the lower median
// of the window in a scoreboard, then checks every median beat against it.
// Depends on swm_pkg, swm_sample_if, swm_median_if and the block itself.

module sliding_window_median_tb;
    import swm_pkg::*;

    localparam int N_ITEMS      = 1450;
    localparam int CALM_TAIL    = 200;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 2 * (WINDOW + 4) + 8;
    localparam int N_DIRECTED   = 24;

    typedef enum int {
        SHAPE_NOISE,
        SHAPE_CLUSTER,
        SHAPE_RAMP_UP,
        SHAPE_RAMP_DOWN,
        SHAPE_FEW_LEVELS,
        SHAPE_SPIKES
    } t_shape;

    // Running model of the window and the queue of medians still owed by the block.
    class median_scoreboard;
        t_sample     window_vals [WINDOW];
        int unsigned wr_pos     = 0;
        int unsigned fill       = 0;
        int unsigned fail_count = 0;
        t_sample     median_q [$];

        function t_sample lower_median();
            t_sample sorted [WINDOW];
            t_sample v;
            int      j;
            for (int i = 0; i < fill; i++) begin
                v = window_vals[i];
                j = i;
                while (j > 0 && sorted[j-1] > v) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            return sorted[(fill - 1) / 2];
        endfunction

        function void note_sample(t_sample s);
            // Store the sentinel one above itself, as the block does.
            window_vals[wr_pos] = (s == SENTINEL) ? t_sample'(SENTINEL + 1) : s;
            wr_pos = (wr_pos == WINDOW - 1) ? 0 : wr_pos + 1;
            if (fill < WINDOW) fill++;
            median_q.push_back(lower_median());
        endfunction

        function void check_median(t_sample got);
            t_sample want;
            if (median_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("median beat %0d with nothing outstanding", got);
            end else begin
                want = median_q.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("median mismatch: expected %0d, got %0d", want, got);
                end
            end
        endfunction

        function int unsigned pending();
            return median_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    swm_sample_if smp_if ();
    swm_median_if med_if ();

    median_scoreboard sb = new;

    int unsigned cycle_count = 0;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          snk_stall = 0;

    // Extremes, the sentinel, a partly filled window with odd and even counts, then wrap.
    t_sample directed_vals [N_DIRECTED] = '{
        16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001,
        16'h0002, 16'hFFFE, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
        16'd100,  16'd100,  16'd100,  16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h8000
    };

    sliding_window_median u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_med   (med_if)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sliding_window_median_tb NOT OK");
            $finish;
        end else if (i_rst_n) begin
            if (smp_if.valid && smp_if.ready) sb.note_sample(smp_if.sample);
            if (med_if.valid && med_if.ready) sb.check_median(med_if.median_value);
        end
    end

    // Sink side: drop ready in bursts of random length.
    always @(negedge i_clk) begin
        if (snk_stall == 0 && $urandom_range(99) < snk_idle_pct)
            snk_stall = $urandom_range(19, 1);
        if (snk_stall > 0) begin
            snk_stall--;
            med_if.ready <= 1'b0;
        end else begin
            med_if.ready <= 1'b1;
        end
    end

    function automatic int pick_idle_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_sample(t_sample s);
        int gap;
        if ($urandom_range(99) < src_idle_pct) begin
            gap = $urandom_range(19, 1);
            smp_if.valid  <= 1'b0;
            smp_if.sample <= t_sample'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        do @(posedge i_clk); while (!smp_if.ready);
        @(negedge i_clk);
    endtask

    initial begin
        t_shape  shape;
        int      run_left;
        t_sample base;
        t_sample step;
        t_sample s;
        int      n_random;

        i_rst_n       = 1'b0;
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        med_if.ready  = 1'b0;
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        run_left      = 0;
        shape         = SHAPE_NOISE;
        base          = '0;
        step          = '0;
        n_random      = N_ITEMS - N_DIRECTED;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 20;
        snk_idle_pct = 20;
        foreach (directed_vals[k]) send_sample(directed_vals[k]);

        for (int n = 0; n < n_random; n++) begin
            if (n >= n_random - CALM_TAIL) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if (n % 100 == 0) begin
                src_idle_pct = pick_idle_pct();
                snk_idle_pct = pick_idle_pct();
            end
            if (run_left == 0) begin
                shape    = t_shape'($urandom_range(5));
                run_left = $urandom_range(40, 8);
                base     = t_sample'($urandom);
                step     = t_sample'($urandom_range(2000, 1));
            end
            run_left--;
            case (shape)
                SHAPE_CLUSTER:   s = base + t_sample'($urandom_range(15));
                SHAPE_RAMP_UP: begin
                    base = base + step;
                    s    = base;
                end
                SHAPE_RAMP_DOWN: begin
                    base = base - step;
                    s    = base;
                end
                SHAPE_FEW_LEVELS: begin
                    case ($urandom_range(3))
                        0:       s = SENTINEL;
                        1:       s = 16'h0001;
                        2:       s = 16'h0002;
                        default: s = 16'hFFFF;
                    endcase
                end
                // Flat level with the odd impulse, which the median should reject.
                SHAPE_SPIKES:    s = ($urandom_range(9) == 0) ? t_sample'($urandom) : base;
                default:         s = t_sample'($urandom);
            endcase
            send_sample(s);
        end
        smp_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("sliding_window_median_tb OK");
        end else begin
            $display("sliding_window_median_tb NOT OK");
        end
        $finish;
    end

endmodule
